// ===== hw/rtl/msd_pkg.sv =====
// Shared types and constants for the motor stall detector.
package msd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int THRESH_W = 16;
    localparam int IN_TDATA_W = 48;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W = 1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [THRESH_W-1:0] t_thresh;

    // One velocity and two drive values moving together along a chain.
    typedef struct packed {
        t_sample left;
        t_sample right;
        t_sample velocity;
    } t_triple;

    localparam t_sample SIG_MAX = 16'sh7FFF;
    localparam t_sample SIG_MIN = -16'sh8000;

    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_DROP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_RISE = 1'b1;

    localparam t_thresh VELOCITY_DROP_RESET = 16'd26;
    localparam t_thresh DRIVE_RISE_RESET = 16'd1280;

endpackage

// ===== hw/rtl/msd_cell.sv =====
// One tap of a delay chain holding a velocity and two drive values.
module msd_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  msd_pkg::t_triple i_prev,
    output msd_pkg::t_triple o_value
);
    import msd_pkg::*;

    t_triple r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
        end else if (i_shift) begin
            r_value <= i_prev;
        end
    end

    assign o_value = r_value;

endmodule

// ===== hw/rtl/msd_avg.sv =====
// Running window sum of one signal with a floor-rounded, saturated average.
module msd_avg #(
    parameter int WINDOW_DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  msd_pkg::t_sample i_sample,
    input  msd_pkg::t_sample i_oldest,
    output msd_pkg::t_sample o_avg
);
    import msd_pkg::*;

    localparam int SumW = SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int Shift = $clog2(WINDOW_DEPTH + 1) - 1;
    localparam logic signed [SumW-1:0] SatMax = SumW'(SIG_MAX);
    localparam logic signed [SumW-1:0] SatMin = SumW'(SIG_MIN);

    logic signed [SumW-1:0] r_sum;
    logic signed [SumW-1:0] n_sum;
    logic signed [SumW-1:0] w_shifted;

    // The sample leaving the window is taken off as the new one comes in.
    assign n_sum = r_sum + SumW'(i_sample) - SumW'(i_oldest);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_load) begin
            r_sum <= n_sum;
        end
    end

    // An arithmetic shift rounds towards minus infinity.
    assign w_shifted = r_sum >>> Shift;

    always_comb begin
        if (w_shifted > SatMax) begin
            o_avg = SIG_MAX;
        end else if (w_shifted < SatMin) begin
            o_avg = SIG_MIN;
        end else begin
            o_avg = w_shifted[SAMPLE_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/motor_stall_detector_core.sv =====
// Top level of the motor stall detector: window and history chains, warm-up and decision.
//
// Usage: each request on the slave stream carries one velocity sample and the
// right and left PWM drive samples. Every request produces exactly one result
// on the master stream, holding the blocked flag and an evaluated bit.
// The two thresholds are written through the plain write port by the user, only while
// the block is idle; it does not enforce this. Index 0: velocity drop, 1: drive rise.
//
// Timing: a request's result passes three register stages (running sums, history
// push, decision) before it shows at the output. A new request is taken every
// cycle while the output is not stalled, so throughput is then one item per clock.
//
// Reset clears the windows, the history, the running sums, the warm-up count
// and the held blocked flag, and loads the thresholds with their defaults.
// When the receiver stalls, the result stays in the output register and the
// stages behind it keep filling; tready falls only once all three are full.
module motor_stall_detector_core #(
    parameter int WINDOW_DEPTH = 4,
    parameter int HISTORY_DEPTH = 10,
    parameter int WARMUP_SAMPLES = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Fields from bit 0: velocity[15:0], drive_right[31:16], drive_left[47:32].
    input  logic [msd_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // Fields from bit 0: blocked[0], evaluated[1], zero fill [7:2].
    output logic [msd_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic                                i_cfg_we,
    input  logic [msd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [msd_pkg::THRESH_W-1:0]        i_cfg_wdata
);
    import msd_pkg::*;

    localparam int CntW = $clog2(WARMUP_SAMPLES + 1);
    localparam logic [CntW-1:0] WarmupLast = CntW'(WARMUP_SAMPLES);
    localparam logic [CntW-1:0] WarmupHold = CntW'(WARMUP_SAMPLES - 1);

    // Configuration registers.
    t_thresh r_vel_thresh;
    t_thresh r_drv_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel_thresh <= VELOCITY_DROP_RESET;
            r_drv_thresh <= DRIVE_RISE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VELOCITY_DROP: r_vel_thresh <= i_cfg_wdata;
                CFG_DRIVE_RISE:    r_drv_thresh <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline flow control: each stage moves on when the one ahead is free.
    logic r_s1_valid, r_s2_valid, r_out_valid;
    logic w_out_free, w_s2_free, w_s1_free;
    logic w_s2_go, w_s1_go, w_accept;

    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_s2_go    = r_s2_valid && w_out_free;
    assign w_s2_free  = !r_s2_valid || w_out_free;
    assign w_s1_go    = r_s1_valid && w_s2_free;
    assign w_s1_free  = !r_s1_valid || w_s2_free;
    assign w_accept   = i_s_axis_tvalid && w_s1_free;
    assign o_s_axis_tready = w_s1_free;

    // Window chain: one cell per window slot, shifted on each accepted request.
    t_triple w_sample;
    t_triple w_win [WINDOW_DEPTH];

    assign w_sample.velocity = i_s_axis_tdata[15:0];
    assign w_sample.right    = i_s_axis_tdata[31:16];
    assign w_sample.left     = i_s_axis_tdata[47:32];

    for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_win
        msd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_accept),
            .i_prev  ((g == 0) ? w_sample : w_win[(g == 0) ? 0 : g - 1]),
            .o_value (w_win[g])
        );
    end

    // Running sums; the oldest window entry drops out as the new one enters.
    t_triple w_avg;

    msd_avg #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_avg_vel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_sample (w_sample.velocity),
        .i_oldest (w_win[WINDOW_DEPTH-1].velocity),
        .o_avg    (w_avg.velocity)
    );

    msd_avg #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_avg_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_sample (w_sample.right),
        .i_oldest (w_win[WINDOW_DEPTH-1].right),
        .o_avg    (w_avg.right)
    );

    msd_avg #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_avg_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_sample (w_sample.left),
        .i_oldest (w_win[WINDOW_DEPTH-1].left),
        .o_avg    (w_avg.left)
    );

    // Warm-up count: after the first evaluation it rests one below the limit,
    // so every later sample is evaluated too.
    logic [CntW-1:0] r_warm_cnt;
    logic [CntW-1:0] n_warm_cnt;
    logic            w_eval_now;
    logic            r_s1_eval, r_s2_eval;

    assign n_warm_cnt = r_warm_cnt + 1'b1;
    assign w_eval_now = (n_warm_cnt == WarmupLast);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm_cnt <= '0;
        end else if (w_accept) begin
            r_warm_cnt <= w_eval_now ? WarmupHold : n_warm_cnt;
        end
    end

    // History chain of averages, newest in cell 0, pushed as stage 1 drains.
    t_triple w_hist [HISTORY_DEPTH];

    for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_hist
        msd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_s1_go),
            .i_prev  ((g == 0) ? w_avg : w_hist[(g == 0) ? 0 : g - 1]),
            .o_value (w_hist[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= w_accept;
            end
            if (w_s2_free) begin
                r_s2_valid <= w_s1_go;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_eval <= w_eval_now;
        end
        if (w_s1_go) begin
            r_s2_eval <= r_s1_eval;
        end
    end

    // Decision: newest against oldest average, exact 17-bit differences.
    logic signed [SAMPLE_W:0] w_drop, w_rise_r, w_rise_l;
    logic signed [SAMPLE_W:0] w_vel_th, w_drv_th;
    logic                     w_hit;
    t_triple                  w_new, w_old;

    assign w_new = w_hist[0];
    assign w_old = w_hist[HISTORY_DEPTH-1];

    assign w_drop   = (SAMPLE_W+1)'(w_old.velocity) - (SAMPLE_W+1)'(w_new.velocity);
    assign w_rise_r = (SAMPLE_W+1)'(w_new.right) - (SAMPLE_W+1)'(w_old.right);
    assign w_rise_l = (SAMPLE_W+1)'(w_new.left) - (SAMPLE_W+1)'(w_old.left);
    assign w_vel_th = $signed({1'b0, r_vel_thresh});
    assign w_drv_th = $signed({1'b0, r_drv_thresh});

    assign w_hit = (w_drop >= w_vel_th) && (w_rise_r >= w_drv_th) &&
                   (w_rise_l >= w_drv_th);

    // Held flag and output register.
    logic r_blocked_flag;
    logic r_out_blocked, r_out_eval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocked_flag <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_s2_go && r_s2_eval) begin
                r_blocked_flag <= w_hit;
            end
            if (w_out_free) begin
                r_out_valid <= w_s2_go;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_go) begin
            r_out_blocked <= r_s2_eval ? w_hit : r_blocked_flag;
            r_out_eval    <= r_s2_eval;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-2){1'b0}}, r_out_eval, r_out_blocked};

endmodule
